FILE: hw/rtl/rci_pkg.sv
// Shared types, constants and register map for the RAMP conductivity interpolator.
`default_nettype none
package rci_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int Q_FRAC        = 8;
    localparam int QUO_W         = 48;
    localparam int GAMMA_W       = 18;
    localparam int LAYER_W       = 4;
    localparam int K_W           = 32;
    localparam int Q_W           = 16;
    localparam int SLOPE_W       = 48;
    localparam int ADDR_W        = 5;
    localparam int DATA_W        = 32;
    localparam int BASE_W        = 4;

    localparam logic [SLOPE_W-1:0] SLOPE_POS_MAX = 48'h7FFF_FFFF_FFFF;
    localparam logic [SLOPE_W-1:0] SLOPE_NEG_MAG = 48'h8000_0000_0000;

    typedef enum logic [1:0] {
        MODE_LINEAR     = 2'd0,
        MODE_RAMP       = 2'd1,
        MODE_HARMONIC   = 2'd2,
        MODE_LINEAR_ALT = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        KSEL_DIRECT = 2'd0,
        KSEL_RAMP   = 2'd1,
        KSEL_HARM   = 2'd2
    } ksel_t;

    localparam logic [2:0] REG_KS   = 3'd0;
    localparam logic [2:0] REG_KF   = 3'd1;
    localparam logic [2:0] REG_Q    = 3'd2;
    localparam logic [2:0] REG_MODE = 3'd3;
    localparam logic [2:0] REG_BASE = 3'd4;

    localparam logic [K_W-1:0]    KS_RESET   = 32'd26214400;
    localparam logic [K_W-1:0]    KF_RESET   = 32'd39322;
    localparam logic [Q_W-1:0]    Q_RESET    = 16'd256;
    localparam mode_t             MODE_RESET = MODE_RAMP;
    localparam logic [BASE_W-1:0] BASE_RESET = 4'd2;

    typedef struct packed {
        logic [K_W-1:0]    ks;
        logic [K_W-1:0]    kf;
        logic [Q_W-1:0]    q;
        mode_t             mode;
        logic [BASE_W-1:0] base;
    } cfg_t;

    typedef struct packed {
        ksel_t          sel;
        logic           diffpos;
        logic [K_W-1:0] k_direct;
        logic           k_ovf;
        logic           k_zero;
        logic           s_ovf;
    } side_t;

endpackage
`default_nettype wire

FILE: hw/rtl/rci_apb_regs.sv
// APB configuration registers of the RAMP conductivity interpolator.
`default_nettype none
module rci_apb_regs
    import rci_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [DATA_W-1:0] pwdata,
    output logic      [DATA_W-1:0] prdata,
    output logic                   pready,
    output cfg_t                   cfg
);

    cfg_t cfg_reg;
    logic [2:0] index;

    assign index  = paddr[4:2];
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.ks   <= KS_RESET;
            cfg_reg.kf   <= KF_RESET;
            cfg_reg.q    <= Q_RESET;
            cfg_reg.mode <= MODE_RESET;
            cfg_reg.base <= BASE_RESET;
        end else if (psel && penable && pwrite) begin
            case (index)
                REG_KS:   cfg_reg.ks   <= pwdata;
                REG_KF:   cfg_reg.kf   <= pwdata;
                REG_Q:    cfg_reg.q    <= pwdata[Q_W-1:0];
                REG_MODE: cfg_reg.mode <= mode_t'(pwdata[1:0]);
                REG_BASE: cfg_reg.base <= pwdata[BASE_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (index)
            REG_KS:   prdata = cfg_reg.ks;
            REG_KF:   prdata = cfg_reg.kf;
            REG_Q:    prdata = {{(DATA_W-Q_W){1'b0}}, cfg_reg.q};
            REG_MODE: prdata = {{(DATA_W-2){1'b0}}, cfg_reg.mode};
            REG_BASE: prdata = {{(DATA_W-BASE_W){1'b0}}, cfg_reg.base};
            default:  prdata = '0;
        endcase
    end

endmodule
`default_nettype wire

FILE: hw/rtl/rci_prep.sv
// Operand pipeline: clamp, products, denominators and overflow pre-checks.
`default_nettype none
module rci_prep
    import rci_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      en,
    input  wire logic                      in_valid,
    input  wire logic signed [GAMMA_W-1:0] cell_gamma,
    input  wire logic [LAYER_W-1:0]        layer,
    input  wire cfg_t                      cfg,
    output logic                           out_valid,
    output side_t                          out_side,
    output logic [FRAC_BITS+31:0]          out_k_den,
    output logic [FRAC_BITS+31:0]          out_k_rem,
    output logic [QUO_W-1:0]               out_k_nq,
    output logic [2*FRAC_BITS+33:0]        out_s_den,
    output logic [2*FRAC_BITS+33:0]        out_s_rem,
    output logic [QUO_W-1:0]               out_s_nq
);

    localparam int G_W     = FRAC_BITS + 1;
    localparam int CMP_W   = (G_W > GAMMA_W) ? G_W : GAMMA_W;
    localparam int DEN_W   = FRAC_BITS + 17;
    localparam int DL_W    = (DEN_W + 1) / 2;
    localparam int DH_W    = DEN_W - DL_W;
    localparam int PK_W    = K_W + G_W;
    localparam int KD_W    = FRAC_BITS + 32;
    localparam int KN_W    = FRAC_BITS + 64;
    localparam int KR_W    = KN_W - QUO_W;
    localparam int SD_W    = 2 * DEN_W;
    localparam int SN_W    = K_W + Q_W + 1;
    localparam int S_SHIFT = 2 * FRAC_BITS + Q_FRAC;
    localparam int SNUM_W  = SN_W + S_SHIFT;
    localparam int SR_W    = SNUM_W - QUO_W;
    localparam logic [G_W-1:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

    // stage 1: clamp density
    logic [CMP_W-1:0] gmag;
    logic [G_W-1:0]   g_next, g_reg, gc_reg;
    logic             v1_reg, base1_reg;
    mode_t            mode1_reg;

    assign gmag = CMP_W'(cell_gamma[GAMMA_W-2:0]);

    always_comb begin
        if (cell_gamma[GAMMA_W-1]) begin
            g_next = '0;
        end else if (gmag > CMP_W'(ONE)) begin
            g_next = ONE;
        end else begin
            g_next = G_W'(gmag);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            g_reg     <= g_next;
            gc_reg    <= ONE - g_next;
            base1_reg <= (layer < cfg.base);
            mode1_reg <= cfg.mode;
        end
    end

    // stage 2: products
    logic             diffpos;
    logic [K_W-1:0]   diffmag;
    logic [DEN_W-1:0] den_next, den_reg;
    logic             v2_reg, base2_reg, diffpos2_reg;
    mode_t            mode2_reg;
    logic [PK_W-1:0]  ksgc_reg, kfg_reg, kfgc_reg, ksg_reg, ramp_reg;
    logic [2*K_W-1:0] kskf_reg;
    logic [SN_W-1:0]  sn_reg;
    logic [Q_W:0]     qp1;

    assign diffpos  = (cfg.ks >= cfg.kf);
    assign diffmag  = diffpos ? cfg.ks - cfg.kf : cfg.kf - cfg.ks;
    assign den_next = (DEN_W'(ONE) << Q_FRAC) + DEN_W'(cfg.q) * DEN_W'(g_reg);
    assign qp1      = {1'b0, cfg.q} + (Q_W+1)'(1 << Q_FRAC);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (en) begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            base2_reg    <= base1_reg;
            mode2_reg    <= mode1_reg;
            diffpos2_reg <= diffpos;
            den_reg      <= den_next;
            ksgc_reg     <= PK_W'(cfg.ks) * PK_W'(gc_reg);
            kfg_reg      <= PK_W'(cfg.kf) * PK_W'(g_reg);
            kfgc_reg     <= PK_W'(cfg.kf) * PK_W'(gc_reg);
            ksg_reg      <= PK_W'(cfg.ks) * PK_W'(g_reg);
            ramp_reg     <= PK_W'(diffmag) * PK_W'(gc_reg);
            kskf_reg     <= (2*K_W)'(cfg.ks) * (2*K_W)'(cfg.kf);
            sn_reg       <= SN_W'(diffmag) * SN_W'(qp1);
        end
    end

    // stage 3: sums, numerators, denominator partial squares
    logic [PK_W:0]       lin_sum;
    logic [PK_W-1:0]     hsum;
    ksel_t               sel_next, sel3_reg;
    logic                v3_reg, diffpos3_reg;
    logic [K_W-1:0]      kdir3_reg;
    logic [KN_W-1:0]     knum_next, knum3_reg;
    logic [KD_W-1:0]     kden_next, kden3_reg;
    logic [SNUM_W-1:0]   snum3_reg;
    logic [DL_W-1:0]     dl;
    logic [DH_W-1:0]     dh;
    logic [2*DL_W-1:0]   ll_reg;
    logic [DL_W+DH_W-1:0] lh_reg;
    logic [2*DH_W-1:0]   hh_reg;

    assign lin_sum = {1'b0, ksgc_reg} + {1'b0, kfg_reg};
    assign hsum    = kfgc_reg + ksg_reg;
    assign dl      = den_reg[DL_W-1:0];
    assign dh      = den_reg[DEN_W-1:DL_W];

    always_comb begin
        if (base2_reg) begin
            sel_next = KSEL_DIRECT;
        end else begin
            case (mode2_reg)
                MODE_RAMP:     sel_next = KSEL_RAMP;
                MODE_HARMONIC: sel_next = KSEL_HARM;
                default:       sel_next = KSEL_DIRECT;
            endcase
        end
        if (sel_next == KSEL_HARM) begin
            knum_next = KN_W'(kskf_reg) << FRAC_BITS;
            kden_next = hsum[KD_W-1:0];
        end else begin
            knum_next = KN_W'(ramp_reg) << Q_FRAC;
            kden_next = KD_W'(den_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v3_reg <= 1'b0;
        end else if (en) begin
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sel3_reg     <= sel_next;
            diffpos3_reg <= diffpos2_reg;
            kdir3_reg    <= base2_reg ? cfg.ks : lin_sum[FRAC_BITS+K_W-1:FRAC_BITS];
            knum3_reg    <= knum_next;
            kden3_reg    <= kden_next;
            snum3_reg    <= SNUM_W'(sn_reg) << S_SHIFT;
            ll_reg       <= (2*DL_W)'(dl) * (2*DL_W)'(dl);
            lh_reg       <= (DL_W+DH_W)'(dl) * (DL_W+DH_W)'(dh);
            hh_reg       <= (2*DH_W)'(dh) * (2*DH_W)'(dh);
        end
    end

    // stage 4: (1+q*g)^2
    logic              v4_reg, diffpos4_reg;
    ksel_t             sel4_reg;
    logic [K_W-1:0]    kdir4_reg;
    logic [KN_W-1:0]   knum4_reg;
    logic [KD_W-1:0]   kden4_reg;
    logic [SNUM_W-1:0] snum4_reg;
    logic [SD_W-1:0]   sden4_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v4_reg <= 1'b0;
        end else if (en) begin
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sel4_reg     <= sel3_reg;
            diffpos4_reg <= diffpos3_reg;
            kdir4_reg    <= kdir3_reg;
            knum4_reg    <= knum3_reg;
            kden4_reg    <= kden3_reg;
            snum4_reg    <= snum3_reg;
            sden4_reg    <= (SD_W'(hh_reg) << (2*DL_W)) + (SD_W'(lh_reg) << (DL_W+1))
                            + SD_W'(ll_reg);
        end
    end

    // stage 5: quotient range checks, divider seed
    logic [KR_W-1:0] khi;
    logic [SR_W-1:0] shi;
    logic            v5_reg;
    side_t           side_reg;
    logic [KD_W-1:0] kden5_reg, krem5_reg;
    logic [QUO_W-1:0] knq5_reg, snq5_reg;
    logic [SD_W-1:0] sden5_reg, srem5_reg;

    assign khi = knum4_reg[KN_W-1:QUO_W];
    assign shi = snum4_reg[SNUM_W-1:QUO_W];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v5_reg <= 1'b0;
        end else if (en) begin
            v5_reg <= v4_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            side_reg.sel      <= sel4_reg;
            side_reg.diffpos  <= diffpos4_reg;
            side_reg.k_direct <= kdir4_reg;
            side_reg.k_ovf    <= (KD_W'(khi) >= kden4_reg);
            side_reg.k_zero   <= (kden4_reg == '0);
            side_reg.s_ovf    <= (SD_W'(shi) >= sden4_reg);
            kden5_reg         <= kden4_reg;
            krem5_reg         <= KD_W'(khi);
            knq5_reg          <= knum4_reg[QUO_W-1:0];
            sden5_reg         <= sden4_reg;
            srem5_reg         <= SD_W'(shi);
            snq5_reg          <= snum4_reg[QUO_W-1:0];
        end
    end

    assign out_valid = v5_reg;
    assign out_side  = side_reg;
    assign out_k_den = kden5_reg;
    assign out_k_rem = krem5_reg;
    assign out_k_nq  = knq5_reg;
    assign out_s_den = sden5_reg;
    assign out_s_rem = srem5_reg;
    assign out_s_nq  = snq5_reg;

endmodule
`default_nettype wire

FILE: hw/rtl/rci_div_cell.sv
// One quotient-bit cell of the two-lane restoring divider chain.
`default_nettype none
module rci_div_cell
    import rci_pkg::*;
#(
    parameter int KD_W = FRAC_BITS_DEF + 32,
    parameter int SD_W = 2 * FRAC_BITS_DEF + 34
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             en,
    input  wire logic             in_valid,
    input  wire side_t            in_side,
    input  wire logic [KD_W-1:0]  in_k_den,
    input  wire logic [KD_W-1:0]  in_k_rem,
    input  wire logic [QUO_W-1:0] in_k_nq,
    input  wire logic [SD_W-1:0]  in_s_den,
    input  wire logic [SD_W-1:0]  in_s_rem,
    input  wire logic [QUO_W-1:0] in_s_nq,
    output logic                  out_valid,
    output side_t                 out_side,
    output logic [KD_W-1:0]       out_k_den,
    output logic [KD_W-1:0]       out_k_rem,
    output logic [QUO_W-1:0]      out_k_nq,
    output logic [SD_W-1:0]       out_s_den,
    output logic [SD_W-1:0]       out_s_rem,
    output logic [QUO_W-1:0]      out_s_nq
);

    logic [KD_W:0] kt, kdiff;
    logic [SD_W:0] st, sdiff;
    logic          kge, sge;

    // shift in the next dividend bit, subtract when it fits
    assign kt    = {in_k_rem, in_k_nq[QUO_W-1]};
    assign kdiff = kt - {1'b0, in_k_den};
    assign kge   = (kt >= {1'b0, in_k_den});
    assign st    = {in_s_rem, in_s_nq[QUO_W-1]};
    assign sdiff = st - {1'b0, in_s_den};
    assign sge   = (st >= {1'b0, in_s_den});

    logic                valid_reg;
    side_t               side_reg;
    logic [KD_W-1:0]     k_den_reg, k_rem_reg;
    logic [QUO_W-1:0]    k_nq_reg, s_nq_reg;
    logic [SD_W-1:0]     s_den_reg, s_rem_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            side_reg  <= in_side;
            k_den_reg <= in_k_den;
            k_rem_reg <= kge ? kdiff[KD_W-1:0] : kt[KD_W-1:0];
            k_nq_reg  <= {in_k_nq[QUO_W-2:0], kge};
            s_den_reg <= in_s_den;
            s_rem_reg <= sge ? sdiff[SD_W-1:0] : st[SD_W-1:0];
            s_nq_reg  <= {in_s_nq[QUO_W-2:0], sge};
        end
    end

    assign out_valid = valid_reg;
    assign out_side  = side_reg;
    assign out_k_den = k_den_reg;
    assign out_k_rem = k_rem_reg;
    assign out_k_nq  = k_nq_reg;
    assign out_s_den = s_den_reg;
    assign out_s_rem = s_rem_reg;
    assign out_s_nq  = s_nq_reg;

endmodule
`default_nettype wire

FILE: hw/rtl/ramp_conductivity_interpolator.sv
// Top level of the RAMP conductivity interpolator: APB registers, pipeline, output stage.
//
// One cell density and layer index goes in per transfer, one result per transfer comes out:
// the interpolated conductivity (linear, RAMP or harmonic rule by the mode setting, solid value
// for layers below the base setting) and the RAMP slope dk/dgamma, with a saturated flag.
// The block takes one item every clock cycle while no held result stalls it. An input
// transfer passes through five operand stages (clamp, products, sums, squared denominator,
// range checks), a chain of 48 divider cells that each resolve one quotient bit of both
// the conductivity and the slope quotient, and the output register. The whole pipeline moves
// together, so s_ready is low only while a result sits in the output register and
// m_ready is low. Register writes are to be made only while the pipeline is empty.
`default_nettype none
module ramp_conductivity_interpolator
    import rci_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    // input channel
    input  wire logic                      s_valid,
    output logic                           s_ready,
    input  wire logic signed [GAMMA_W-1:0] s_cell_gamma,
    input  wire logic [LAYER_W-1:0]        s_layer,
    // result channel
    output logic                           m_valid,
    input  wire logic                      m_ready,
    output logic [K_W-1:0]                 m_conductivity,
    output logic signed [SLOPE_W-1:0]      m_slope,
    output logic                           m_saturated,
    // configuration
    input  wire logic                      psel,
    input  wire logic                      penable,
    input  wire logic                      pwrite,
    input  wire logic [ADDR_W-1:0]         paddr,
    input  wire logic [DATA_W-1:0]         pwdata,
    output logic [DATA_W-1:0]              prdata,
    output logic                           pready
);

    localparam int KD_W = FRAC_BITS + 32;
    localparam int SD_W = 2 * FRAC_BITS + 34;

    cfg_t cfg;
    logic en;

    // whole pipe advances unless a finished result is held back
    assign en      = !m_valid || m_ready;
    assign s_ready = en;

    rci_apb_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // divider chain taps: index 0 is the operand pipeline output
    logic             c_valid [0:QUO_W];
    side_t            c_side  [0:QUO_W];
    logic [KD_W-1:0]  c_k_den [0:QUO_W];
    logic [KD_W-1:0]  c_k_rem [0:QUO_W];
    logic [QUO_W-1:0] c_k_nq  [0:QUO_W];
    logic [SD_W-1:0]  c_s_den [0:QUO_W];
    logic [SD_W-1:0]  c_s_rem [0:QUO_W];
    logic [QUO_W-1:0] c_s_nq  [0:QUO_W];

    rci_prep #(
        .FRAC_BITS (FRAC_BITS)
    ) u_prep (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .en         (en),
        .in_valid   (s_valid && s_ready),
        .cell_gamma (s_cell_gamma),
        .layer      (s_layer),
        .cfg        (cfg),
        .out_valid  (c_valid[0]),
        .out_side   (c_side[0]),
        .out_k_den  (c_k_den[0]),
        .out_k_rem  (c_k_rem[0]),
        .out_k_nq   (c_k_nq[0]),
        .out_s_den  (c_s_den[0]),
        .out_s_rem  (c_s_rem[0]),
        .out_s_nq   (c_s_nq[0])
    );

    for (genvar i = 0; i < QUO_W; i++) begin : g_cell
        rci_div_cell #(
            .KD_W (KD_W),
            .SD_W (SD_W)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (en),
            .in_valid  (c_valid[i]),
            .in_side   (c_side[i]),
            .in_k_den  (c_k_den[i]),
            .in_k_rem  (c_k_rem[i]),
            .in_k_nq   (c_k_nq[i]),
            .in_s_den  (c_s_den[i]),
            .in_s_rem  (c_s_rem[i]),
            .in_s_nq   (c_s_nq[i]),
            .out_valid (c_valid[i+1]),
            .out_side  (c_side[i+1]),
            .out_k_den (c_k_den[i+1]),
            .out_k_rem (c_k_rem[i+1]),
            .out_k_nq  (c_k_nq[i+1]),
            .out_s_den (c_s_den[i+1]),
            .out_s_rem (c_s_rem[i+1]),
            .out_s_nq  (c_s_nq[i+1])
        );
    end

    // final result formatting
    side_t               fs;
    logic [QUO_W-1:0]    kq, sq;
    logic [K_W-1:0]      k_next;
    logic                ksat, ssat;
    logic [SLOPE_W-1:0]  lim, smag, slope_next;

    assign fs = c_side[QUO_W];
    assign kq = c_k_nq[QUO_W];
    assign sq = c_s_nq[QUO_W];

    always_comb begin
        ksat = 1'b0;
        case (fs.sel)
            KSEL_RAMP: begin
                // quotient never exceeds |ks-kf|, so this stays within ks..kf
                k_next = fs.diffpos ? cfg.kf + kq[K_W-1:0] : cfg.kf - kq[K_W-1:0];
            end
            KSEL_HARM: begin
                if (fs.k_zero) begin
                    k_next = '0;
                end else if (fs.k_ovf || kq[QUO_W-1:K_W] != '0) begin
                    k_next = '1;
                    ksat   = 1'b1;
                end else begin
                    k_next = kq[K_W-1:0];
                end
            end
            default: k_next = fs.k_direct;
        endcase
    end

    always_comb begin
        lim  = fs.diffpos ? SLOPE_NEG_MAG : SLOPE_POS_MAX;
        ssat = fs.s_ovf || (sq > lim);
        smag = ssat ? lim : sq;
        // slope is negative when solid conducts better than fluid
        slope_next = fs.diffpos ? SLOPE_W'(0) - smag : smag;
    end

    logic                 m_valid_reg;
    logic [K_W-1:0]       m_conductivity_reg;
    logic [SLOPE_W-1:0]   m_slope_reg;
    logic                 m_saturated_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= c_valid[QUO_W];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_conductivity_reg <= k_next;
            m_slope_reg        <= slope_next;
            m_saturated_reg    <= ksat || ssat;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_conductivity = m_conductivity_reg;
    assign m_slope        = $signed(m_slope_reg);
    assign m_saturated    = m_saturated_reg;

    // a held result must block new input
    a_stall_blocks_input: assert property (
        @(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_ready) |-> !s_ready
    ) else $error("input accepted while result held");

    // the flag means one result sits at a clip limit
    a_sat_at_limit: assert property (
        @(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_saturated_reg) |->
            (m_conductivity_reg == '1 || m_slope_reg == SLOPE_POS_MAX
             || m_slope_reg == SLOPE_NEG_MAG)
    ) else $error("saturated flag without a clipped result");

endmodule
`default_nettype wire

FILE: dv/tb.sv
// Self-checking testbench for the RAMP conductivity interpolator.
`timescale 1ns / 100ps
`default_nettype none
module tb;
    import rci_pkg::*;

    localparam int FRAC  = FRAC_BITS_DEF;
    localparam int DRAIN = 60;              // pipeline depth plus margin

    typedef struct {
        logic [K_W-1:0]     k;
        logic [SLOPE_W-1:0] s;
        logic               sat;
    } cell_result_t;

    logic                      aclk = 1'b0;
    logic                      aresetn = 1'b0;
    logic                      s_valid = 1'b0;
    logic                      s_ready;
    logic signed [GAMMA_W-1:0] s_cell_gamma = '0;
    logic [LAYER_W-1:0]        s_layer = '0;
    logic                      m_valid;
    logic                      m_ready = 1'b0;
    logic [K_W-1:0]            m_conductivity;
    logic signed [SLOPE_W-1:0] m_slope;
    logic                      m_saturated;
    logic                      psel = 1'b0;
    logic                      penable = 1'b0;
    logic                      pwrite = 1'b0;
    logic [ADDR_W-1:0]         paddr = '0;
    logic [DATA_W-1:0]         pwdata = '0;
    logic [DATA_W-1:0]         prdata;
    logic                      pready;

    // shadow copy of the register file
    logic [K_W-1:0]    cfg_ks   = KS_RESET;
    logic [K_W-1:0]    cfg_kf   = KF_RESET;
    logic [Q_W-1:0]    cfg_q    = Q_RESET;
    mode_t             cfg_mode = MODE_RESET;
    logic [BASE_W-1:0] cfg_base = BASE_RESET;

    cell_result_t pending_cells[$];
    int           mismatches = 0;
    int           cells_sent = 0;
    int           cells_checked = 0;
    int           sat_seen = 0;
    bit           no_idle = 1'b0;       // forces back-to-back transfers on both sides

    ramp_conductivity_interpolator DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_cell_gamma(s_cell_gamma), .s_layer(s_layer),
        .m_valid(m_valid), .m_ready(m_ready), .m_conductivity(m_conductivity),
        .m_slope(m_slope), .m_saturated(m_saturated),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always #5 aclk = ~aclk;

    // Conductivity and RAMP slope of one cell under the current registers.
    // All quotients truncate; 128-bit temporaries hold the exact products.
    function automatic cell_result_t conductivity_of(logic [GAMMA_W-1:0] graw,
                                                     logic [LAYER_W-1:0] lyr);
        cell_result_t r;
        logic [63:0]  one, g, gc, ks, kf, q, diffmag, den, k, lim, smag;
        logic [127:0] w, num, dsum;
        logic         diffpos, sat;
        one = 64'd1 << FRAC;
        ks = cfg_ks;
        kf = cfg_kf;
        q = cfg_q;
        sat = 1'b0;
        // clamp density to [0, 1.0]
        if (graw[GAMMA_W-1]) g = 0;
        else g = (graw > one) ? one : graw;
        gc = one - g;
        diffpos = ks >= kf;
        diffmag = diffpos ? ks - kf : kf - ks;
        den = (one << Q_FRAC) + q * g;          // 1 + q*g, FRAC+8 fraction bits

        if (lyr < cfg_base) begin
            k = ks;
        end else if (cfg_mode == MODE_RAMP) begin
            w = (128'(diffmag) * 128'(gc << Q_FRAC)) / 128'(den);
            k = diffpos ? kf + w[63:0] : kf - w[63:0];
        end else if (cfg_mode == MODE_HARMONIC) begin
            dsum = 128'(gc) * 128'(kf) + 128'(g) * 128'(ks);
            num = (128'(ks) * 128'(kf)) << FRAC;
            w = (dsum == 0) ? 128'd0 : num / dsum;   // 0/0 gives 0
            if (w > 128'h0FFFF_FFFF) begin
                k = 64'hFFFF_FFFF;
                sat = 1'b1;
            end else begin
                k = w[63:0];
            end
        end else begin
            k = (ks * gc + kf * g) >> FRAC;
        end
        if (k > 64'hFFFF_FFFF) begin
            k = 64'hFFFF_FFFF;
            sat = 1'b1;
        end

        // slope magnitude |ks-kf|(1+q)/(1+q*g)^2
        num = 128'(diffmag * ((64'd1 << Q_FRAC) + q)) << (2 * FRAC + Q_FRAC);
        w = num / (128'(den) * 128'(den));
        lim = diffpos ? 64'(SLOPE_NEG_MAG) : 64'(SLOPE_POS_MAX);
        if (w > 128'(lim)) begin
            smag = lim;
            sat = 1'b1;
        end else begin
            smag = w[63:0];
        end
        r.k = k[K_W-1:0];
        r.s = diffpos ? SLOPE_W'(-smag) : smag[SLOPE_W-1:0];
        r.sat = sat;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        mismatches++;
        $display("t=%0t mismatch on %s: got %h, expected %h", $realtime, what, got, want);
    endtask

    // APB write: setup, then access; lands at the access edge.
    task automatic write_reg(input logic [2:0] idx, input logic [DATA_W-1:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_KS:   cfg_ks = value;
            REG_KF:   cfg_kf = value;
            REG_Q:    cfg_q = value[Q_W-1:0];
            REG_MODE: cfg_mode = mode_t'(value[1:0]);
            REG_BASE: cfg_base = value[BASE_W-1:0];
            default: ;
        endcase
    endtask

    task automatic load_config(input logic [K_W-1:0] ks, input logic [K_W-1:0] kf,
                               input logic [Q_W-1:0] q, input mode_t mode,
                               input logic [BASE_W-1:0] base);
        write_reg(REG_KS, ks);
        write_reg(REG_KF, kf);
        write_reg(REG_Q, 32'(q));
        write_reg(REG_MODE, 32'(mode));
        write_reg(REG_BASE, 32'(base));
    endtask

    // Send one cell; called at a rising edge, returns at the edge of its transfer.
    task automatic send_cell(input logic [GAMMA_W-1:0] gamma, input logic [LAYER_W-1:0] lyr);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 11);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_cell_gamma <= gamma;
        s_layer <= lyr;
        do @(posedge aclk); while (!s_ready);
        pending_cells.insert(pending_cells.size(), conductivity_of(gamma, lyr));
        cells_sent++;
    endtask

    // Stop sending and let the pipeline empty before any register write.
    task automatic drain;
        s_valid <= 1'b0;
        while (pending_cells.size() != 0) @(posedge aclk);
        repeat (DRAIN) @(posedge aclk);
    endtask

    // Result side: random stall per result, then compare against the oldest expectation.
    initial begin
        cell_result_t want;
        int stall;
        @(posedge aresetn);
        forever begin
            stall = no_idle ? 0 : $urandom_range(0, 11);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            cells_checked++;
            if (pending_cells.size() == 0) begin
                report_mismatch("unexpected result", 64'(m_conductivity), 64'd0);
            end else begin
                want = pending_cells.pop_front();
                if (m_conductivity !== want.k)
                    report_mismatch("conductivity", 64'(m_conductivity), 64'(want.k));
                if (m_slope !== want.s)
                    report_mismatch("slope", 64'(m_slope), 64'(want.s));
                if (m_saturated !== want.sat)
                    report_mismatch("saturated", 64'(m_saturated), 64'(want.sat));
                if (want.sat) sat_seen++;
            end
        end
    end

    // Density edges (negative, zero, one LSB, 1.0, just above, max) on alternating layers 1 and 15, then layer 2.
    task automatic test_density_edges;
        logic [GAMMA_W-1:0] edges[8];
        edges = '{18'h20000, 18'h3FFFF, 18'h0, 18'h1, 18'hFFFF, 18'h10000, 18'h10001, 18'h1FFFF};
        foreach (edges[i]) send_cell(edges[i], (i % 2) ? 4'd15 : 4'd1);
        send_cell(18'h08000, 4'd2);
    endtask

    // Every mode, including the alternate linear code, at quarter and three-quarter density.
    task automatic test_modes;
        mode_t m;
        m = m.first();
        do begin
            drain();
            write_reg(REG_MODE, 32'(m));
            send_cell(18'h04000, 4'd5);
            send_cell(18'h0C000, 4'd9);
            m = m.next();
        end while (m != m.first());
    endtask

    // Register extremes: all-zero conductivities (harmonic 0/0), solid below fluid,
    // largest values with q at max, and no layer solid or all but layer 15.
    task automatic test_register_extremes;
        drain();
        load_config(32'd0, 32'd0, 16'd0, MODE_HARMONIC, 4'd0);
        send_cell(18'h0, 4'd0);
        send_cell(18'h08000, 4'd3);
        drain();
        load_config(32'd1000, 32'hFFFF_FFFF, 16'hFFFF, MODE_RAMP, 4'd0);
        send_cell(18'h0, 4'd0);
        send_cell(18'h10000, 4'd7);
        send_cell(18'h00100, 4'd7);
        drain();
        load_config(32'hFFFF_FFFF, 32'd0, 16'hFFFF, MODE_HARMONIC, 4'd15);
        send_cell(18'h0, 4'd14);
        send_cell(18'h12345, 4'd15);
        drain();
        write_reg(REG_MODE, 32'(MODE_LINEAR));
        send_cell(18'h0AAAA, 4'd15);
    endtask

    // Random phases: a fresh register setting each phase, then a burst of cells.
    task automatic test_random_phases(input int phases, input int per_phase);
        logic [GAMMA_W-1:0] gamma;
        logic [K_W-1:0]     ks, kf;
        for (int p = 0; p < phases; p++) begin
            drain();
            ks = (p % 3 == 0) ? $urandom() : $urandom() >> $urandom_range(0, 31);
            kf = (p % 4 == 0) ? $urandom() : $urandom() >> $urandom_range(0, 31);
            load_config(ks, kf, 16'($urandom()), mode_t'($urandom_range(0, 3)),
                        4'($urandom_range(0, 15)));
            no_idle = (p % 5 == 4);
            for (int i = 0; i < per_phase; i++) begin
                // mostly in-range densities, some anywhere in the field
                gamma = ($urandom_range(0, 3) == 0) ? 18'($urandom())
                                                    : 18'($urandom_range(0, 65536));
                send_cell(gamma, 4'($urandom()));
            end
            no_idle = 1'b0;
        end
    endtask

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_density_edges();
        test_modes();
        test_register_extremes();
        test_random_phases(20, 35);
        drain();
        $display("Sent %0d cells, checked %0d results (%0d saturated) across all modes,",
                 cells_sent, cells_checked, sat_seen);
        $display("density and layer extremes, the reset registers and 28 written settings.");
        if (mismatches == 0 && pending_cells.size() == 0) begin
            $display("[ramp_conductivity_interpolator] OK");
        end else begin
            $display("[ramp_conductivity_interpolator] ERROR");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial begin
        #3ms;
        $display("timeout with %0d results outstanding", pending_cells.size());
        $display("[ramp_conductivity_interpolator] ERROR");
        $finish;
    end

endmodule
`default_nettype wire
